// ===== rtl/pwc_pkg.sv =====
`timescale 1ns / 1ps

package pwc_pkg;

    // Field widths.
    localparam int unsigned CountWidth = 16;
    localparam int unsigned SegWidth   = 8;
    localparam int unsigned RegIdxWidth = 2;

    // Saturation value of the 16-bit quiet counter.
    localparam logic [CountWidth-1:0] Max16 = 16'hFFFF;

    // Active-low seven-segment patterns.
    localparam logic [SegWidth-1:0] SEG_P = 8'h8C;
    localparam logic [SegWidth-1:0] SEG_H = 8'h89;
    localparam logic [SegWidth-1:0] SEG_L = 8'hC7;

    // Reset values of the configuration registers and the measured half period.
    localparam logic [CountWidth-1:0] FastDivReset   = 16'd50;
    localparam logic [CountWidth-1:0] MediumDivReset = 16'd250;
    localparam logic [CountWidth-1:0] SlowDivReset   = 16'd1250;
    localparam logic [CountWidth-1:0] TimeoutReset   = 16'd500;
    localparam logic [CountWidth-1:0] HalfReset      = 16'd200;

    // Configuration register indexes.
    typedef enum logic [RegIdxWidth-1:0] {
        REG_FAST_DIVISOR   = 2'd0,
        REG_MEDIUM_DIVISOR = 2'd1,
        REG_SLOW_DIVISOR   = 2'd2,
        REG_TIMEOUT_LIMIT  = 2'd3
    } reg_idx_t;

    // Input item: one timer tick.
    typedef struct packed {
        logic probe_level;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic                  fast_wave;
        logic                  medium_wave;
        logic                  slow_wave;
        logic                  is_wave;
        logic [SegWidth-1:0]   segment_code;
        logic [CountWidth-1:0] half_period;
    } out_item_t;

    // Configuration write item.
    typedef struct packed {
        reg_idx_t              index;
        logic [CountWidth-1:0] data;
    } cfg_item_t;

endpackage

// ===== rtl/pwc_stream_if.sv =====
`timescale 1ns / 1ps

// Valid/ready channel carrying one item of payload_t.
interface pwc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== rtl/probe_wave_classifier_core.sv =====
`timescale 1ns / 1ps

// Logic probe with three built-in test square waves. Every item on the probe
// channel is one timer tick with the sampled probe level, and it produces
// exactly one result item: the three test wave levels, the wave/steady
// verdict, a seven-segment code (P, H or L) and the last measured half period.
// An item is taken in every cycle unless a result waits on a stalled consumer:
// the whole update is one step of counter, increment and compare logic that
// writes the state and the result register at the same edge, so the result is
// registered in the cycle after its tick and the next tick can enter as it is
// taken. Input ready drops only while a result is held by the consumer.
// Configuration writes are accepted in every cycle and must be issued only while no tick is in flight.
module probe_wave_classifier_core (
    input  logic            clk,
    input  logic            rst_n,
    pwc_stream_if.sink      probe,
    pwc_stream_if.source    result,
    pwc_stream_if.sink      cfg
);

    localparam int unsigned W = pwc_pkg::CountWidth;

    // Configuration registers.
    logic [W-1:0] fast_div_reg;
    logic [W-1:0] medium_div_reg;
    logic [W-1:0] slow_div_reg;
    logic [W-1:0] timeout_reg;

    // Classifier state.
    logic [W-1:0] fast_cnt_reg,   fast_cnt_next;
    logic [W-1:0] medium_cnt_reg, medium_cnt_next;
    logic [W-1:0] slow_cnt_reg,   slow_cnt_next;
    logic [2:0]   levels_reg,     levels_next;
    logic [W-1:0] quiet_reg,      quiet_next;
    logic [W-1:0] half_reg,       half_next;
    logic         prev_probe_reg, prev_probe_next;
    logic         flag_reg,       flag_next;

    // Result register.
    logic                out_valid_reg;
    pwc_pkg::out_item_t  out_data_reg, out_data_next;

    logic         in_acc;
    logic         probe_bit;
    logic         edge_seen;
    logic [W:0]   fast_inc, medium_inc, slow_inc;
    logic [W:0]   threshold;
    logic [W-1:0] quiet_inc;

    // Handshakes.
    assign probe.ready    = !out_valid_reg || result.ready;
    assign cfg.ready      = 1'b1;
    assign in_acc         = probe.valid && probe.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;
    assign probe_bit      = probe.payload.probe_level;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_div_reg   <= pwc_pkg::FastDivReset;
            medium_div_reg <= pwc_pkg::MediumDivReset;
            slow_div_reg   <= pwc_pkg::SlowDivReset;
            timeout_reg    <= pwc_pkg::TimeoutReset;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                pwc_pkg::REG_FAST_DIVISOR:   fast_div_reg   <= cfg.payload.data;
                pwc_pkg::REG_MEDIUM_DIVISOR: medium_div_reg <= cfg.payload.data;
                pwc_pkg::REG_SLOW_DIVISOR:   slow_div_reg   <= cfg.payload.data;
                pwc_pkg::REG_TIMEOUT_LIMIT:  timeout_reg    <= cfg.payload.data;
                default: ;
            endcase
        end
    end

    // Test wave dividers: a counter that reaches or passes its divisor
    // toggles the wave and restarts from zero.
    always_comb
    begin
        fast_inc    = {1'b0, fast_cnt_reg} + 17'd1;
        medium_inc  = {1'b0, medium_cnt_reg} + 17'd1;
        slow_inc    = {1'b0, slow_cnt_reg} + 17'd1;
        levels_next = levels_reg;

        fast_cnt_next = fast_inc[W-1:0];
        if (fast_inc >= {1'b0, fast_div_reg})
        begin
            fast_cnt_next  = '0;
            levels_next[0] = ~levels_reg[0];
        end

        medium_cnt_next = medium_inc[W-1:0];
        if (medium_inc >= {1'b0, medium_div_reg})
        begin
            medium_cnt_next = '0;
            levels_next[1]  = ~levels_reg[1];
        end

        slow_cnt_next = slow_inc[W-1:0];
        if (slow_inc >= {1'b0, slow_div_reg})
        begin
            slow_cnt_next  = '0;
            levels_next[2] = ~levels_reg[2];
        end
    end

    // Edge detection, quiet counting and the wave verdict.
    always_comb
    begin
        edge_seen       = probe_bit != prev_probe_reg;
        quiet_inc       = (quiet_reg == pwc_pkg::Max16) ? quiet_reg : quiet_reg + 16'd1;
        threshold       = {1'b0, half_reg} + {3'b000, half_reg[W-1:2]};
        quiet_next      = quiet_inc;
        half_next       = half_reg;
        prev_probe_next = prev_probe_reg;
        flag_next       = flag_reg;

        if (edge_seen)
        begin
            // The gap since the last edge is the quiet count plus this tick.
            half_next       = quiet_inc;
            quiet_next      = '0;
            prev_probe_next = probe_bit;
            flag_next       = 1'b1;
        end
        else
        begin
            if (flag_reg && ({1'b0, quiet_inc} > threshold))
            begin
                flag_next = 1'b0;
            end
            if (quiet_inc >= timeout_reg)
            begin
                flag_next = 1'b0;
            end
        end
    end

    // Result assembly from the updated state.
    always_comb
    begin
        out_data_next.fast_wave   = levels_next[0];
        out_data_next.medium_wave = levels_next[1];
        out_data_next.slow_wave   = levels_next[2];
        out_data_next.is_wave     = flag_next;
        out_data_next.half_period = half_next;
        if (flag_next)
        begin
            out_data_next.segment_code = pwc_pkg::SEG_P;
        end
        else if (probe_bit)
        begin
            out_data_next.segment_code = pwc_pkg::SEG_H;
        end
        else
        begin
            out_data_next.segment_code = pwc_pkg::SEG_L;
        end
    end

    // State update on every accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_cnt_reg   <= '0;
            medium_cnt_reg <= '0;
            slow_cnt_reg   <= '0;
            levels_reg     <= 3'b111;
            quiet_reg      <= '0;
            half_reg       <= pwc_pkg::HalfReset;
            prev_probe_reg <= 1'b0;
            flag_reg       <= 1'b0;
        end
        else if (in_acc)
        begin
            fast_cnt_reg   <= fast_cnt_next;
            medium_cnt_reg <= medium_cnt_next;
            slow_cnt_reg   <= slow_cnt_next;
            levels_reg     <= levels_next;
            quiet_reg      <= quiet_next;
            half_reg       <= half_next;
            prev_probe_reg <= prev_probe_next;
            flag_reg       <= flag_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; loaded only when a new item is taken.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // An accepted item always leaves a result waiting in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("accepted item produced no result");

    // The P pattern is shown exactly when the wave verdict is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (out_data_reg.is_wave == (out_data_reg.segment_code == pwc_pkg::SEG_P)))
        else $error("segment code disagrees with wave verdict");

    // A set wave flag never sits above the 1.25 half period threshold.
    assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |-> ({1'b0, quiet_reg} <= threshold))
        else $error("wave flag held past the quiet threshold");

    // A tick without an edge advances the quiet counter by one below saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !edge_seen && quiet_reg != pwc_pkg::Max16) |=>
            (quiet_reg == $past(quiet_reg) + 16'd1))
        else $error("quiet counter did not advance");

    // An edge restarts the quiet counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && edge_seen) |=> (quiet_reg == '0 && flag_reg))
        else $error("edge did not restart quiet counting");

endmodule

// ===== verif/tb_probe_wave_classifier_core.sv =====
`timescale 1ns / 1ps

module tb_probe_wave_classifier_core;

    localparam int CycleLimit = 2_000_000;
    localparam int IdlePct    = 23;
    localparam int NumPhases  = 10;
    localparam int PhaseItems = 155;

    typedef logic [pwc_pkg::CountWidth-1:0] count_t;

    typedef enum logic { ROW_TICK, ROW_WRITE } row_kind_t;

    // One row of the directed script: a tick or a register write.
    typedef struct {
        row_kind_t          kind;
        logic               level;
        pwc_pkg::reg_idx_t  idx;
        count_t             data;
        bit                 typed;
        pwc_pkg::out_item_t want;
    } stim_row_t;

    // Predicted state of the classifier.
    typedef struct {
        count_t     fast_cnt;
        count_t     medium_cnt;
        count_t     slow_cnt;
        logic [2:0] levels;
        count_t     quiet;
        count_t     half;
        logic       last_probe;
        logic       flag;
    } probe_track_t;

    logic clk;
    logic rst_n;

    pwc_stream_if #(.payload_t(pwc_pkg::in_item_t))  probe_if ();
    pwc_stream_if #(.payload_t(pwc_pkg::out_item_t)) result_if ();
    pwc_stream_if #(.payload_t(pwc_pkg::cfg_item_t)) cfg_if ();

    probe_wave_classifier_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .probe  (probe_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    probe_track_t          probe_trk;
    count_t                setting [4];
    pwc_pkg::out_item_t    expected_results [$];
    stim_row_t             script [$];
    int                    mismatch_count;
    int                    result_count;
    int                    cycle_count;
    bit                    steady_stretch;
    logic                  probe_now;
    bit                    cur_typed;
    pwc_pkg::out_item_t    cur_want;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CycleLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Consumer stalls: random back-pressure on the result channel.
    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            result_if.ready <= rst_n && (steady_stretch || $urandom_range(99) >= IdlePct);
        end
    end

    // Returns the toggle flag and the next count of one test-wave divider.
    function automatic logic [pwc_pkg::CountWidth:0] next_divider(input count_t cnt,
                                                                  input count_t div);
        logic [pwc_pkg::CountWidth:0] inc;
        inc = {1'b0, cnt} + 1'b1;
        if (inc >= {1'b0, div})
            return {1'b1, {pwc_pkg::CountWidth{1'b0}}};
        return {1'b0, inc[pwc_pkg::CountWidth-1:0]};
    endfunction

    function automatic void reset_tracker();
        setting[pwc_pkg::REG_FAST_DIVISOR]   = pwc_pkg::FastDivReset;
        setting[pwc_pkg::REG_MEDIUM_DIVISOR] = pwc_pkg::MediumDivReset;
        setting[pwc_pkg::REG_SLOW_DIVISOR]   = pwc_pkg::SlowDivReset;
        setting[pwc_pkg::REG_TIMEOUT_LIMIT]  = pwc_pkg::TimeoutReset;
        probe_trk.fast_cnt   = '0;
        probe_trk.medium_cnt = '0;
        probe_trk.slow_cnt   = '0;
        probe_trk.levels     = 3'b111;
        probe_trk.quiet      = '0;
        probe_trk.half       = pwc_pkg::HalfReset;
        probe_trk.last_probe = 1'b0;
        probe_trk.flag       = 1'b0;
    endfunction

    // Advances the predicted state by one tick and returns the expected result.
    function automatic pwc_pkg::out_item_t classify_tick(input logic level);
        logic [pwc_pkg::CountWidth:0]   step;
        logic [pwc_pkg::CountWidth+1:0] bound;
        pwc_pkg::out_item_t             r;

        step = next_divider(probe_trk.fast_cnt, setting[pwc_pkg::REG_FAST_DIVISOR]);
        probe_trk.fast_cnt = step[pwc_pkg::CountWidth-1:0];
        probe_trk.levels[0] ^= step[pwc_pkg::CountWidth];
        step = next_divider(probe_trk.medium_cnt, setting[pwc_pkg::REG_MEDIUM_DIVISOR]);
        probe_trk.medium_cnt = step[pwc_pkg::CountWidth-1:0];
        probe_trk.levels[1] ^= step[pwc_pkg::CountWidth];
        step = next_divider(probe_trk.slow_cnt, setting[pwc_pkg::REG_SLOW_DIVISOR]);
        probe_trk.slow_cnt = step[pwc_pkg::CountWidth-1:0];
        probe_trk.levels[2] ^= step[pwc_pkg::CountWidth];

        if (level != probe_trk.last_probe) begin
            // An edge: the gap since the previous edge becomes the half period.
            probe_trk.half = (probe_trk.quiet == pwc_pkg::Max16) ? pwc_pkg::Max16
                                                                 : probe_trk.quiet + 1'b1;
            probe_trk.quiet = '0;
            probe_trk.last_probe = level;
            probe_trk.flag = 1'b1;
        end else begin
            if (probe_trk.quiet != pwc_pkg::Max16)
                probe_trk.quiet = probe_trk.quiet + 1'b1;
            // The threshold of 1.25 half periods is kept wide enough not to wrap.
            bound = {2'b00, probe_trk.half}
                    + {4'b0000, probe_trk.half[pwc_pkg::CountWidth-1:2]};
            if (probe_trk.flag && {2'b00, probe_trk.quiet} > bound)
                probe_trk.flag = 1'b0;
            if (probe_trk.quiet >= setting[pwc_pkg::REG_TIMEOUT_LIMIT])
                probe_trk.flag = 1'b0;
        end

        r.fast_wave    = probe_trk.levels[0];
        r.medium_wave  = probe_trk.levels[1];
        r.slow_wave    = probe_trk.levels[2];
        r.is_wave      = probe_trk.flag;
        r.segment_code = probe_trk.flag ? pwc_pkg::SEG_P
                                        : (level ? pwc_pkg::SEG_H : pwc_pkg::SEG_L);
        r.half_period  = probe_trk.half;
        return r;
    endfunction

    // Scoreboard: predicts accepted ticks, applies register writes and checks results.
    always @(posedge clk) begin
        pwc_pkg::out_item_t got;
        pwc_pkg::out_item_t want;
        pwc_pkg::out_item_t predicted;
        if (rst_n) begin
            if (probe_if.valid && probe_if.ready) begin
                predicted = classify_tick(probe_if.payload.probe_level);
                expected_results.push_back(cur_typed ? cur_want : predicted);
            end
            if (cfg_if.valid && cfg_if.ready)
                setting[cfg_if.payload.index] = cfg_if.payload.data;
            if (result_if.valid && result_if.ready) begin
                got = result_if.payload;
                result_count++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d arrived with no item pending: %h",
                                 result_count, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.fast_wave !== want.fast_wave
                            || got.medium_wave !== want.medium_wave
                            || got.slow_wave !== want.slow_wave
                            || got.is_wave !== want.is_wave
                            || got.segment_code !== want.segment_code
                            || got.half_period !== want.half_period) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d: expected fast=%b medium=%b slow=%b ",
                                      "wave=%b seg=%h half=%0d, got fast=%b medium=%b ",
                                      "slow=%b wave=%b seg=%h half=%0d"},
                                     result_count, want.fast_wave, want.medium_wave,
                                     want.slow_wave, want.is_wave, want.segment_code,
                                     want.half_period, got.fast_wave, got.medium_wave,
                                     got.slow_wave, got.is_wave, got.segment_code,
                                     got.half_period);
                    end
                end
            end
        end
    end

    function automatic pwc_pkg::out_item_t make_result(
            input logic f, input logic m, input logic s, input logic w,
            input logic [pwc_pkg::SegWidth-1:0] seg, input count_t half);
        pwc_pkg::out_item_t r;
        r.fast_wave    = f;
        r.medium_wave  = m;
        r.slow_wave    = s;
        r.is_wave      = w;
        r.segment_code = seg;
        r.half_period  = half;
        return r;
    endfunction

    function automatic void add_tick(input logic level, input bit typed,
                                     input pwc_pkg::out_item_t want);
        stim_row_t row;
        row.kind  = ROW_TICK;
        row.level = level;
        row.idx   = pwc_pkg::REG_FAST_DIVISOR;
        row.data  = '0;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endfunction

    function automatic void add_write(input pwc_pkg::reg_idx_t idx, input count_t data);
        stim_row_t row;
        row.kind  = ROW_WRITE;
        row.level = 1'b0;
        row.idx   = idx;
        row.data  = data;
        row.typed = 1'b0;
        row.want  = '0;
        script.push_back(row);
    endfunction

    // Sends one tick, with random idle cycles ahead of it. Starts and ends at a falling edge.
    task automatic send_tick(input logic level, input bit typed,
                             input pwc_pkg::out_item_t want);
        while (!steady_stretch && $urandom_range(99) < IdlePct) begin
            probe_if.valid <= 1'b0;
            @(negedge clk);
        end
        probe_if.valid <= 1'b1;
        probe_if.payload.probe_level <= level;
        cur_typed <= typed;
        cur_want  <= want;
        probe_now = level;
        @(posedge clk);
        while (!(probe_if.valid && probe_if.ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_run(input logic level, input int len);
        repeat (len) send_tick(level, 1'b0, '0);
    endtask

    // Waits until every result of the ticks sent so far has been taken.
    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Writes one register once the block is idle. Called at a falling edge.
    task automatic write_reg(input pwc_pkg::reg_idx_t idx, input count_t data);
        probe_if.valid <= 1'b0;
        wait_drained();
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.payload.index <= idx;
        cfg_if.payload.data  <= data;
        @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready))
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Random register value: mostly short periods, with zero, full scale and wide values.
    function automatic count_t pick_setting(input pwc_pkg::reg_idx_t idx);
        case ($urandom_range(9))
            0: return '0;
            1: return pwc_pkg::Max16;
            2: return count_t'($urandom);
            default: return (idx == pwc_pkg::REG_TIMEOUT_LIMIT)
                            ? count_t'($urandom_range(1, 150))
                            : count_t'($urandom_range(1, 40));
        endcase
    endfunction

    // Random ticks: mostly square bursts, with steady stretches and noise.
    // Every run is cut where the phase's share of items runs out.
    task automatic random_phase(input int quota);
        int sent;
        int pick;
        int hp;
        int halves;
        int len;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                hp = ($urandom_range(3) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 12);
                halves = $urandom_range(2, 12);
                repeat (halves) begin
                    len = hp;
                    if ($urandom_range(9) == 0)
                        len = $urandom_range(1, hp + hp / 2 + 1);
                    if (len > quota - sent)
                        len = quota - sent;
                    send_run(~probe_now, len);
                    sent += len;
                end
            end else if (pick < 90) begin
                len = $urandom_range(1, 120);
                if (len > quota - sent)
                    len = quota - sent;
                send_run(1'($urandom_range(1)), len);
                sent += len;
            end else begin
                len = $urandom_range(1, 16);
                if (len > quota - sent)
                    len = quota - sent;
                repeat (len) send_tick(1'($urandom_range(1)), 1'b0, '0);
                sent += len;
            end
        end
    endtask

    // Main sequence.
    initial begin
        int writes;
        pwc_pkg::reg_idx_t idx;

        rst_n = 1'b0;
        probe_if.valid = 1'b0;
        probe_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        cur_typed = 1'b0;
        cur_want = '0;
        probe_now = 1'b0;
        steady_stretch = 1'b0;
        mismatch_count = 0;
        result_count = 0;
        reset_tracker();

        // Directed script: reset behavior, then the divider and timeout corners.
        add_tick(1'b0, 1'b1, make_result(1'b1, 1'b1, 1'b1, 1'b0, pwc_pkg::SEG_L,
                                         pwc_pkg::HalfReset));
        add_tick(1'b1, 1'b1, make_result(1'b1, 1'b1, 1'b1, 1'b1, pwc_pkg::SEG_P, 16'd2));
        add_tick(1'b1, 1'b1, make_result(1'b1, 1'b1, 1'b1, 1'b1, pwc_pkg::SEG_P, 16'd2));
        add_tick(1'b1, 1'b1, make_result(1'b1, 1'b1, 1'b1, 1'b1, pwc_pkg::SEG_P, 16'd2));
        add_tick(1'b1, 1'b1, make_result(1'b1, 1'b1, 1'b1, 1'b0, pwc_pkg::SEG_H, 16'd2));
        // A zero divisor toggles every tick; a zero timeout drops the flag on every quiet tick.
        add_write(pwc_pkg::REG_FAST_DIVISOR, '0);
        add_write(pwc_pkg::REG_TIMEOUT_LIMIT, '0);
        add_tick(1'b1, 1'b0, '0);
        add_tick(1'b0, 1'b0, '0);
        add_tick(1'b0, 1'b0, '0);
        add_tick(1'b0, 1'b0, '0);
        add_write(pwc_pkg::REG_FAST_DIVISOR, pwc_pkg::Max16);
        add_write(pwc_pkg::REG_MEDIUM_DIVISOR, 16'd1);
        add_write(pwc_pkg::REG_SLOW_DIVISOR, pwc_pkg::Max16);
        add_tick(1'b1, 1'b0, '0);
        add_tick(1'b0, 1'b0, '0);
        add_tick(1'b1, 1'b0, '0);
        // Lowering the slow divisor below its running count forces a toggle.
        add_write(pwc_pkg::REG_SLOW_DIVISOR, 16'd3);
        add_write(pwc_pkg::REG_TIMEOUT_LIMIT, pwc_pkg::Max16);
        add_tick(1'b1, 1'b0, '0);
        add_tick(1'b1, 1'b0, '0);
        add_tick(1'b0, 1'b0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE)
                write_reg(script[i].idx, script[i].data);
            else
                send_tick(script[i].level, script[i].typed, script[i].want);
        end

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < NumPhases; phase++) begin
            if (phase == 0) begin
                for (int r = 0; r < 4; r++)
                    write_reg(pwc_pkg::reg_idx_t'(r), 16'd1);
            end else if (phase == 1) begin
                for (int r = 0; r < 4; r++)
                    write_reg(pwc_pkg::reg_idx_t'(r), pwc_pkg::Max16);
            end else begin
                writes = $urandom_range(1, 4);
                repeat (writes) begin
                    idx = pwc_pkg::reg_idx_t'($urandom_range(3));
                    write_reg(idx, pick_setting(idx));
                end
            end
            steady_stretch = (phase == 4);
            random_phase(PhaseItems);
        end
        steady_stretch = 1'b0;

        probe_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        mismatch_count += expected_results.size();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pwc_pkg.sv
rtl/pwc_stream_if.sv
rtl/probe_wave_classifier_core.sv
verif/tb_probe_wave_classifier_core.sv
